// ----- hdl/hsvs_pkg.sv -----
`default_nettype none
package hsvs_pkg;

    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int CH_W    = 8;
    localparam int SHADE_W = 2;
    localparam int SECT_W  = 3;

    localparam logic [SHADE_W-1:0] SHADE_DARK = 2'd0;
    localparam logic [SHADE_W-1:0] SHADE_BASE = 2'd1;
    localparam logic [SHADE_W-1:0] SHADE_HIGH = 2'd2;

    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
    localparam logic [CH_W-1:0]  CH_MAX   = 8'd255;

    typedef struct packed {
        logic               valid;
        logic [SHADE_W-1:0] shade;
        logic [HUE_W-1:0]   hue;
        logic [PCT_W-1:0]   sat;
        logic [PCT_W-1:0]   val;
    } t_conv_req;

    typedef struct packed {
        logic               valid;
        logic [SHADE_W-1:0] shade;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
    } t_conv_res;

    // floor(n / 255), exact for n <= 65279 (covers all 8x8-bit products)
    function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] n);
        logic [2*CH_W:0] acc;
        acc = {1'b0, n} + 17'd1 + {9'd0, n[2*CH_W-1:CH_W]};
        return acc[2*CH_W-1:CH_W];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/hsvs_in_if.sv -----
`default_nettype none
interface hsvs_in_if import hsvs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
    logic [PCT_W-1:0] contrast;

    modport source (output valid, hue, saturation, brightness, contrast, input ready);
    modport sink   (input valid, hue, saturation, brightness, contrast, output ready);
endinterface
`default_nettype wire

// ----- hdl/hsvs_out_if.sv -----
`default_nettype none
interface hsvs_out_if import hsvs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SHADE_W-1:0] shade;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic               last;

    modport source (output valid, shade, red, green, blue, last, input ready);
    modport sink   (input valid, shade, red, green, blue, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/hsv_shade_triplet_to_rgb.sv -----
`default_nettype none
// HSV shade triplet to RGB.
// Input channel i_px carries one HSV color (hue 0..359 degrees, saturation and
// brightness in percent) plus a contrast amount. For each input transaction the
// output channel o_px delivers three RGB transactions in order: dark shade,
// base shade and highlight shade; last is set on the highlight.
// Path: after the input is accepted, each shade passes core stages r_a, r_b,
// r_c and the output register; shades leave in order when the receiver is ready.
// Throughput: one input per shade triplet, set by the one-result-per-cycle output
// channel; the conversion pipeline takes a new shade every cycle unless stalled.
// The input holding register accepts the next transaction while the third
// shade of the current one is issued, so back-to-back inputs run without gaps.
// Reset (synchronous, active low) empties the holding register and all stages.
// When the receiver stalls, the whole pipeline holds; nothing is dropped or
// repeated.
module hsv_shade_triplet_to_rgb import hsvs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hsvs_in_if.sink    i_px,
    hsvs_out_if.source o_px
);

    logic               r_item_valid;
    logic [SHADE_W-1:0] r_cnt;
    logic [HUE_W-1:0]   r_hue;
    logic [PCT_W-1:0]   r_sat, r_val, r_con;
    t_conv_res          r_out;

    logic             en;
    t_conv_req        req;
    t_conv_res        res;
    logic [PCT_W:0]   hi_sum;
    logic [10:0]      hi_n;
    logic [23:0]      hi_prod;
    logic [PCT_W-1:0] hi_s, hi_v, dark_v;

    assign en         = !r_out.valid || o_px.ready;
    assign i_px.ready = !r_item_valid || (en && r_cnt == SHADE_HIGH);

    // highlight saturation: (9*sat + 5) / 10 via reciprocal 6554 / 2^16
    always_comb begin
        hi_n    = {1'b0, r_sat, 3'd0} + {4'd0, r_sat} + 11'd5;
        hi_prod = {13'd0, hi_n} * 24'd6554;
        hi_s    = (hi_prod[23:16] > {1'b0, PCT_MAX}) ? PCT_MAX : hi_prod[22:16];
        hi_sum  = {1'b0, r_val} + {1'b0, r_con};
        hi_v    = (hi_sum > {1'b0, PCT_MAX}) ? PCT_MAX : hi_sum[PCT_W-1:0];
        dark_v  = (r_val > r_con) ? r_val - r_con : '0;
        req.valid = r_item_valid;
        req.shade = r_cnt;
        req.hue   = r_hue;
        unique case (r_cnt)
            SHADE_DARK: begin req.sat = r_sat; req.val = dark_v; end
            SHADE_BASE: begin req.sat = r_sat; req.val = r_val;  end
            default:    begin req.sat = hi_s;  req.val = hi_v;   end
        endcase
    end

    hsvs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_req   (req),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_cnt        <= SHADE_DARK;
            r_out.valid  <= 1'b0;
        end else begin
            if (en) begin
                r_out <= res;
            end
            priority if (i_px.valid && i_px.ready) begin
                r_item_valid <= 1'b1;
                r_cnt        <= SHADE_DARK;
                r_hue        <= i_px.hue;
                r_sat        <= i_px.saturation;
                r_val        <= i_px.brightness;
                r_con        <= i_px.contrast;
            end else if (en && r_item_valid) begin
                if (r_cnt == SHADE_HIGH) begin
                    r_cnt        <= SHADE_DARK;
                    r_item_valid <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 2'd1;
                end
            end
        end
    end

    assign o_px.valid = r_out.valid;
    assign o_px.shade = r_out.shade;
    assign o_px.red   = r_out.red;
    assign o_px.green = r_out.green;
    assign o_px.blue  = r_out.blue;
    assign o_px.last  = (r_out.shade == SHADE_HIGH);

endmodule
`default_nettype wire

// ----- hdl/hsvs_core.sv -----
`default_nettype none
module hsvs_core import hsvs_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_conv_req i_req,
    output t_conv_res      o_res
);

    typedef struct packed {
        logic               valid;
        logic [SHADE_W-1:0] shade;
        logic [CH_W-1:0]    s;
        logic [CH_W-1:0]    v;
        logic [SECT_W-1:0]  sector;
        logic [CH_W-1:0]    frac;
    } t_stage_b;

    typedef struct packed {
        logic               valid;
        logic [SHADE_W-1:0] shade;
        logic [CH_W-1:0]    v;
        logic [CH_W-1:0]    p;
        logic [CH_W-1:0]    sf;
        logic [CH_W-1:0]    sfn;
        logic [SECT_W-1:0]  sector;
    } t_stage_c;

    t_conv_req r_a;
    t_stage_b  r_b, n_b;
    t_stage_c  r_c, n_c;

    logic [PCT_W-1:0]  sc, vc;
    logic [19:0]       s_prod, v_prod;
    logic [HUE_W-1:0]  h;
    logic [5:0]        rem;
    logic [SECT_W-1:0] sector;
    logic [9:0]        rem17;
    logic [CH_W-1:0]   q, t;

    // scale percent to 0..255: x*255/100 == (x*10445) >> 12 for x <= 100
    always_comb begin
        sc     = (r_a.sat > PCT_MAX) ? PCT_MAX : r_a.sat;
        vc     = (r_a.val > PCT_MAX) ? PCT_MAX : r_a.val;
        s_prod = {13'd0, sc} * 20'd10445;
        v_prod = {13'd0, vc} * 20'd10445;
        h      = (r_a.hue >= HUE_WRAP) ? r_a.hue - HUE_WRAP : r_a.hue;
        priority if (h >= 9'd300) begin
            sector = 3'd5; rem = 6'(h - 9'd300);
        end else if (h >= 9'd240) begin
            sector = 3'd4; rem = 6'(h - 9'd240);
        end else if (h >= 9'd180) begin
            sector = 3'd3; rem = 6'(h - 9'd180);
        end else if (h >= 9'd120) begin
            sector = 3'd2; rem = 6'(h - 9'd120);
        end else if (h >= 9'd60) begin
            sector = 3'd1; rem = 6'(h - 9'd60);
        end else begin
            sector = 3'd0; rem = 6'(h);
        end
        rem17       = {rem, 4'd0} + {4'd0, rem};
        n_b.valid   = r_a.valid;
        n_b.shade   = r_a.shade;
        n_b.s       = s_prod[19:12];
        n_b.v       = v_prod[19:12];
        n_b.sector  = sector;
        n_b.frac    = rem17[9:2];
    end

    always_comb begin
        n_c.valid  = r_b.valid;
        n_c.shade  = r_b.shade;
        n_c.v      = r_b.v;
        n_c.sector = r_b.sector;
        n_c.p      = div255({8'd0, r_b.v} * {8'd0, CH_MAX - r_b.s});
        n_c.sf     = div255({8'd0, r_b.s} * {8'd0, r_b.frac});
        n_c.sfn    = div255({8'd0, r_b.s} * {8'd0, CH_MAX - r_b.frac});
    end

    always_comb begin
        q           = div255({8'd0, r_c.v} * {8'd0, CH_MAX - r_c.sf});
        t           = div255({8'd0, r_c.v} * {8'd0, CH_MAX - r_c.sfn});
        o_res.valid = r_c.valid;
        o_res.shade = r_c.shade;
        unique case (r_c.sector)
            3'd0:    begin o_res.red = r_c.v; o_res.green = t;     o_res.blue = r_c.p; end
            3'd1:    begin o_res.red = q;     o_res.green = r_c.v; o_res.blue = r_c.p; end
            3'd2:    begin o_res.red = r_c.p; o_res.green = r_c.v; o_res.blue = t;     end
            3'd3:    begin o_res.red = r_c.p; o_res.green = q;     o_res.blue = r_c.v; end
            3'd4:    begin o_res.red = t;     o_res.green = r_c.p; o_res.blue = r_c.v; end
            default: begin o_res.red = r_c.v; o_res.green = r_c.p; o_res.blue = q;     end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
        end else if (i_en) begin
            r_a <= i_req;
            r_b <= n_b;
            r_c <= n_c;
        end
    end

endmodule
`default_nettype wire
